FILE: src/chu_pkg.sv
`timescale 1ns / 1ps
package chu_pkg;

	localparam int unsigned KEY_W      = 31;
	localparam int unsigned OP_W       = 2;
	localparam int unsigned STATUS_W   = 2;
	localparam int unsigned CFG_W      = 7;

	localparam int unsigned DEF_BUCKETS    = 64;
	localparam int unsigned DEF_NODES      = 256;
	localparam int unsigned DEF_VALUE_BITS = 32;

	localparam logic [CFG_W-1:0] BUCKET_COUNT_RESET = 7'd64;

	localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
	localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;
	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

endpackage

FILE: src/chu_if.sv
`timescale 1ns / 1ps
interface chu_req_if import chu_pkg::*; #(
	parameter int unsigned VALUE_BITS = DEF_VALUE_BITS
);
	logic                  valid;
	logic                  ready;
	logic [OP_W-1:0]       op;
	logic [KEY_W-1:0]      key;
	logic [VALUE_BITS-1:0] value;

	modport source (output valid, op, key, value, input ready);
	modport sink (input valid, op, key, value, output ready);
endinterface

interface chu_rsp_if import chu_pkg::*; #(
	parameter int unsigned VALUE_BITS = DEF_VALUE_BITS,
	parameter int unsigned COUNT_W    = 9
);
	logic                  valid;
	logic                  ready;
	logic [STATUS_W-1:0]   status;
	logic [VALUE_BITS-1:0] found_value;
	logic [COUNT_W-1:0]    item_count;

	modport source (output valid, status, found_value, item_count, input ready);
	modport sink (input valid, status, found_value, item_count, output ready);
endinterface

interface chu_cfg_if import chu_pkg::*;;
	logic             valid;
	logic             ready;
	logic [CFG_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

FILE: src/chained_hash_table_unit.sv
`timescale 1ns / 1ps
// keyed table with separate chaining, bucket = key mod bucket_count
// req: op, key, value words; add, remove, lookup or clear all
// rsp: one word per request with status, found_value and item_count
// cfg: bucket_count, write only while no request is in flight; zero acts as 1,
//   values above BUCKETS act as BUCKETS
// one request at a time: req.ready is low from accept until the response is taken
// steps: a bit-serial modulo of the key, a read of the bucket head, a read of
//   each chain node visited, an update, then the response; clear skips these
//   and goes straight to the response
// a stalled response holds its word and blocks the next request
// reset empties every bucket, frees every node and sets bucket_count to 64;
//   no clearing pass is needed, the table is usable right after reset
module chained_hash_table_unit import chu_pkg::*; #(
	parameter int unsigned BUCKETS    = DEF_BUCKETS,
	parameter int unsigned NODES      = DEF_NODES,
	parameter int unsigned VALUE_BITS = DEF_VALUE_BITS
) (
	input  logic  clk,
	input  logic  arst_n,
	chu_req_if.sink   req,
	chu_rsp_if.source rsp,
	chu_cfg_if.sink   cfg
);

	localparam int unsigned DW  = $clog2(BUCKETS + 1);
	localparam int unsigned BIW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

	logic [CFG_W-1:0] bucket_count_q;
	logic [DW-1:0]    divisor;
	logic             mod_start;
	logic             mod_done;
	logic [DW-1:0]    rem;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			bucket_count_q <= BUCKET_COUNT_RESET;
		else if (cfg.valid)
			bucket_count_q <= cfg.data;
	end

	always_comb begin
		if (bucket_count_q == '0)
			divisor = DW'(1);
		else if (32'(bucket_count_q) > BUCKETS)
			divisor = DW'(BUCKETS);
		else
			divisor = DW'(bucket_count_q);
	end

	chu_mod #(
		.DW(DW)
	) u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mod_start),
		.key     (req.key),
		.divisor (divisor),
		.done    (mod_done),
		.rem     (rem)
	);

	chu_table #(
		.BUCKETS    (BUCKETS),
		.NODES      (NODES),
		.VALUE_BITS (VALUE_BITS),
		.BIW        (BIW)
	) u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.mod_start (mod_start),
		.mod_done  (mod_done),
		.bucket    (BIW'(rem))
	);

endmodule

FILE: src/chu_mod.sv
`timescale 1ns / 1ps
module chu_mod import chu_pkg::*; #(
	parameter int unsigned DW = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [KEY_W-1:0] key,
	input  logic [DW-1:0]    divisor,
	output logic             done,
	output logic [DW-1:0]    rem
);

	localparam int unsigned CNT_W = $clog2(KEY_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [KEY_W-1:0] key_q;
	logic [DW-1:0]    div_q;
	logic [DW-1:0]    rem_q;
	logic [DW:0]      trial;
	logic [DW:0]      diff;

	// one restoring step per cycle, key bits from the top
	assign trial = {rem_q, key_q[KEY_W-1]};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(KEY_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			key_q <= key;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			key_q <= {key_q[KEY_W-2:0], 1'b0};
			if (trial >= {1'b0, div_q})
				rem_q <= diff[DW-1:0];
			else
				rem_q <= trial[DW-1:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

FILE: src/chu_table.sv
`timescale 1ns / 1ps
module chu_table import chu_pkg::*; #(
	parameter int unsigned BUCKETS    = DEF_BUCKETS,
	parameter int unsigned NODES      = DEF_NODES,
	parameter int unsigned VALUE_BITS = DEF_VALUE_BITS,
	parameter int unsigned BIW        = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
	input  logic           clk,
	input  logic           arst_n,
	chu_req_if.sink        req,
	chu_rsp_if.source      rsp,
	output logic           mod_start,
	input  logic           mod_done,
	input  logic [BIW-1:0] bucket
);

	localparam int unsigned NIW = $clog2(NODES + 1);
	localparam int unsigned NAW = $clog2(NODES);
	localparam logic [NIW-1:0] NIL = NIW'(NODES);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_MOD   = 8'b0000_0010,
		S_HEAD  = 8'b0000_0100,
		S_FIRST = 8'b0000_1000,
		S_CHK   = 8'b0001_0000,
		S_RD    = 8'b0010_0000,
		S_ACT   = 8'b0100_0000,
		S_RESP  = 8'b1000_0000
	} state_t;

	state_t                state_q;
	logic [OP_W-1:0]       op_q;
	logic [KEY_W-1:0]      key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [BIW-1:0]        bkt_q;
	logic [NIW-1:0]        cur_q;
	logic [NIW-1:0]        prev_q;
	logic [NIW-1:0]        head_q;
	logic [NIW-1:0]        nxt_q;
	logic                  found_q;
	logic [VALUE_BITS-1:0] fval_q;
	logic [STATUS_W-1:0]   status_q;
	logic [VALUE_BITS-1:0] fv_q;
	logic [NIW-1:0]        count_q;
	logic [NIW-1:0]        alloc_q;
	logic [NIW-1:0]        top_q;
	logic [BUCKETS-1:0]    bvalid_q;

	logic [NIW-1:0]        head_mem [BUCKETS];
	logic [KEY_W-1:0]      key_mem [NODES];
	logic [VALUE_BITS-1:0] val_mem [NODES];
	logic [NIW-1:0]        next_mem [NODES];
	logic [NIW-1:0]        stack_mem [NODES];

	logic [NIW-1:0]        head_rd_q;
	logic [KEY_W-1:0]      key_rd_q;
	logic [VALUE_BITS-1:0] val_rd_q;
	logic [NIW-1:0]        next_rd_q;
	logic [NIW-1:0]        stk_rd_q;

	logic                  do_add;
	logic                  do_rem;
	logic [NIW-1:0]        new_node;
	logic                  head_we;
	logic [NIW-1:0]        head_wd;
	logic                  next_we;
	logic [NAW-1:0]        next_wa;
	logic [NIW-1:0]        next_wd;
	logic [NIW-1:0]        top_m1;

	assign top_m1 = top_q - 1'b1;

	// nodes never handed out since clear come from alloc_q, recycled ones from the stack
	assign new_node = (top_q != '0) ? stk_rd_q : alloc_q;
	assign do_add = (state_q == S_ACT) && (op_q == OP_ADD) && !found_q
		&& (count_q != NIL);
	assign do_rem = (state_q == S_ACT) && (op_q == OP_REMOVE) && found_q;

	always_comb begin
		head_we = 1'b0;
		head_wd = new_node;
		next_we = 1'b0;
		next_wa = new_node[NAW-1:0];
		next_wd = head_q;
		if (do_add) begin
			head_we = 1'b1;
			next_we = 1'b1;
		end else if (do_rem) begin
			if (prev_q == NIL) begin
				head_we = 1'b1;
				head_wd = nxt_q;
			end else begin
				next_we = 1'b1;
				next_wa = prev_q[NAW-1:0];
				next_wd = nxt_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (head_we)
			head_mem[bkt_q] <= head_wd;
		head_rd_q <= head_mem[bkt_q];
	end

	always_ff @(posedge clk) begin
		if (do_add) begin
			key_mem[new_node[NAW-1:0]] <= key_q;
			val_mem[new_node[NAW-1:0]] <= val_q;
		end
		key_rd_q <= key_mem[cur_q[NAW-1:0]];
		val_rd_q <= val_mem[cur_q[NAW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (next_we)
			next_mem[next_wa] <= next_wd;
		next_rd_q <= next_mem[cur_q[NAW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (do_rem)
			stack_mem[top_q[NAW-1:0]] <= cur_q;
		stk_rd_q <= stack_mem[top_m1[NAW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			alloc_q  <= '0;
			top_q    <= '0;
			bvalid_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						if (req.op == OP_CLEAR) begin
							count_q  <= '0;
							alloc_q  <= '0;
							top_q    <= '0;
							bvalid_q <= '0;
							state_q  <= S_RESP;
						end else begin
							state_q <= S_MOD;
						end
					end
				end
				S_MOD: begin
					if (mod_done)
						state_q <= S_HEAD;
				end
				S_HEAD:  state_q <= S_FIRST;
				S_FIRST: state_q <= S_CHK;
				S_CHK: begin
					if (cur_q == NIL)
						state_q <= S_ACT;
					else
						state_q <= S_RD;
				end
				S_RD: begin
					if (key_rd_q == key_q)
						state_q <= S_ACT;
					else
						state_q <= S_CHK;
				end
				S_ACT: begin
					if (do_add) begin
						bvalid_q[bkt_q] <= 1'b1;
						count_q <= count_q + 1'b1;
						if (top_q != '0)
							top_q <= top_m1;
						else
							alloc_q <= alloc_q + 1'b1;
					end else if (do_rem) begin
						count_q <= count_q - 1'b1;
						top_q   <= top_q + 1'b1;
					end
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (rsp.ready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q     <= req.op;
				key_q    <= req.key;
				val_q    <= req.value;
				status_q <= ST_OK;
				fv_q     <= '0;
			end
			S_MOD: begin
				if (mod_done)
					bkt_q <= bucket;
			end
			S_FIRST: begin
				cur_q   <= bvalid_q[bkt_q] ? head_rd_q : NIL;
				head_q  <= bvalid_q[bkt_q] ? head_rd_q : NIL;
				prev_q  <= NIL;
				found_q <= 1'b0;
			end
			S_RD: begin
				if (key_rd_q == key_q) begin
					found_q <= 1'b1;
					nxt_q   <= next_rd_q;
					fval_q  <= val_rd_q;
				end else begin
					prev_q <= cur_q;
					cur_q  <= next_rd_q;
				end
			end
			S_ACT: begin
				status_q <= ST_OK;
				fv_q     <= '0;
				if (op_q == OP_ADD) begin
					if (!found_q && count_q == NIL)
						status_q <= ST_FULL;
				end else if (!found_q) begin
					status_q <= ST_NOT_FOUND;
				end else if (op_q == OP_LOOKUP) begin
					fv_q <= fval_q;
				end
			end
			default: ;
		endcase
	end

	assign req.ready       = (state_q == S_IDLE);
	assign mod_start       = req.valid && (state_q == S_IDLE) && (req.op != OP_CLEAR);
	assign rsp.valid       = (state_q == S_RESP);
	assign rsp.status      = status_q;
	assign rsp.found_value = fv_q;
	assign rsp.item_count  = count_q;

endmodule

FILE: test/chained_hash_table_unit_checker.sv
`timescale 1ns / 1ps
module chained_hash_table_unit_checker import chu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	chu_req_if.sink   req_mon,
	chu_rsp_if.sink   rsp_mon,
	chu_cfg_if.sink   cfg_mon,
	output int        fail_count,
	output int        pending
);
	localparam int NB = 64;
	localparam int NN = 256;
	localparam logic [8:0] NIL = 9'd256;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [31:0]         found_value;
		logic [8:0]          item_count;
	} answer_t;

	answer_t     answer_q[$];
	logic [6:0]  buckets_cfg;
	logic [8:0]  head[NB];
	logic [30:0] nkey[NN];
	logic [31:0] nval[NN];
	logic [8:0]  nnext[NN];
	logic [8:0]  nprev[NN];
	logic [8:0]  free_stack[NN];
	int          free_top;
	logic [8:0]  entries;

	task automatic wipe_table();
		for (int i = 0; i < NB; i++) head[i] = NIL;
		for (int i = 0; i < NN; i++) free_stack[i] = 9'(i);
		free_top = NN;
		entries = '0;
	endtask

	function automatic int bucket_for(logic [30:0] k);
		int n;
		n = int'(buckets_cfg);
		if (n == 0) n = 1;
		if (n > NB) n = NB;
		return int'(k % n);
	endfunction

	function automatic logic [8:0] chain_search(int b, logic [30:0] k);
		logic [8:0] cur;
		int steps;
		cur = head[b];
		steps = 0;
		while (cur < NIL && steps < NN) begin
			if (nkey[cur] == k) return cur;
			cur = nnext[cur];
			steps++;
		end
		return NIL;
	endfunction

	task automatic apply_request(logic [OP_W-1:0] op, logic [30:0] k, logic [31:0] v);
		answer_t a;
		int b;
		logic [8:0] n, p, q;
		a = '0;
		b = bucket_for(k);
		case (op)
			OP_ADD: begin
				if (chain_search(b, k) == NIL) begin
					if (free_top == 0) a.status = ST_FULL;
					else begin
						free_top--;
						n = free_stack[free_top];
						nkey[n] = k;
						nval[n] = v;
						nprev[n] = NIL;
						nnext[n] = head[b];
						if (head[b] < NIL) nprev[head[b]] = n;
						head[b] = n;
						entries++;
					end
				end
			end
			OP_REMOVE: begin
				n = chain_search(b, k);
				if (n == NIL) a.status = ST_NOT_FOUND;
				else begin
					p = nprev[n];
					q = nnext[n];
					if (head[b] == n) head[b] = q;
					else if (p < NIL) nnext[p] = q;
					if (q < NIL) nprev[q] = (head[b] == q) ? NIL : p;
					if (free_top < NN) begin
						free_stack[free_top] = n;
						free_top++;
					end
					if (entries > 0) entries--;
				end
			end
			OP_LOOKUP: begin
				n = chain_search(b, k);
				if (n == NIL) a.status = ST_NOT_FOUND;
				else a.found_value = nval[n];
			end
			default: wipe_table();
		endcase
		a.item_count = entries;
		answer_q.push_back(a);
	endtask

	assign pending = answer_q.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fail_count <= 0;
			buckets_cfg = BUCKET_COUNT_RESET;
			wipe_table();
			answer_q.delete();
		end else begin
			if (cfg_mon.valid && cfg_mon.ready) buckets_cfg = cfg_mon.data;
			if (req_mon.valid && req_mon.ready)
				apply_request(req_mon.op, req_mon.key, req_mon.value);
			if (rsp_mon.valid && rsp_mon.ready) begin
				if (answer_q.size() == 0) begin
					$display("%0t: unexpected word st=%0d val=%h cnt=%0d", $time,
						rsp_mon.status, rsp_mon.found_value, rsp_mon.item_count);
					fail_count <= fail_count + 1;
				end else begin
					answer_t e;
					e = answer_q.pop_front();
					if (e.status !== rsp_mon.status || e.found_value !== rsp_mon.found_value
						|| e.item_count !== rsp_mon.item_count) begin
						$display("%0t: mismatch expected st=%0d val=%h cnt=%0d actual st=%0d val=%h cnt=%0d",
							$time, e.status, e.found_value, e.item_count,
							rsp_mon.status, rsp_mon.found_value, rsp_mon.item_count);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

FILE: test/chained_hash_table_unit_test.sv
`timescale 1ns / 1ps
module chained_hash_table_unit_test;
	import chu_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   fail_count, pending;
	int   cycle_count = 0;
	int   send_idle = 0, recv_idle = 0;
	int   sent_items = 0;
	logic [30:0] key_pool[8];

	chu_req_if req();
	chu_rsp_if rsp();
	chu_cfg_if cfg();

	chained_hash_table_unit dut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp), .cfg(cfg));

	chained_hash_table_unit_checker chk (.clk(clk), .arst_n(arst_n), .req_mon(req),
		.rsp_mon(rsp), .cfg_mon(cfg), .fail_count(fail_count), .pending(pending));

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		req.valid = 1'b0; req.op = OP_ADD; req.key = '0; req.value = '0;
		rsp.ready = 1'b0; cfg.valid = 1'b0; cfg.data = '0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		rsp.ready <= ($urandom_range(99) >= recv_idle);
		if (cycle_count > 2000000) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic send_word(logic [OP_W-1:0] op, logic [30:0] k, logic [31:0] v);
		while ($urandom_range(99) < send_idle) @(posedge clk);
		req.valid <= 1'b1; req.op <= op; req.key <= k; req.value <= v;
		do @(posedge clk); while (!req.ready);
		req.valid <= 1'b0;
		sent_items++;
		// the block is never ready in the cycle after an accept
		@(posedge clk);
	endtask

	task automatic write_buckets(logic [6:0] n);
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		cfg.valid <= 1'b1; cfg.data <= n;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
	endtask

	task automatic random_phase(int count);
		logic [30:0] k;
		logic [1:0] op;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(9))
				0: k = 31'($urandom);
				1: k = 31'h7FFFFFFF;
				default: k = key_pool[$urandom_range(7)] + 31'($urandom_range(40));
			endcase
			op = ($urandom_range(49) == 0) ? OP_CLEAR : 2'($urandom_range(2));
			send_word(op, k, $urandom);
		end
	endtask

	initial begin
		for (int i = 0; i < 8; i++) key_pool[i] = 31'($urandom);
		key_pool[0] = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle = 15; recv_idle = 81;
		// directed: extremes, collisions on one bucket, misses, clear
		send_word(OP_LOOKUP, 31'd5, 32'd0);
		send_word(OP_REMOVE, 31'd5, 32'd0);
		send_word(OP_ADD, 31'd0, 32'hFFFFFFFF);
		send_word(OP_ADD, 31'h7FFFFFFF, 32'h0);
		send_word(OP_ADD, 31'd64, 32'hA5A5A5A5);
		send_word(OP_ADD, 31'd128, 32'h5A5A5A5A);
		send_word(OP_ADD, 31'd64, 32'h12345678);
		send_word(OP_LOOKUP, 31'd64, 32'd0);
		send_word(OP_REMOVE, 31'd64, 32'd0);
		send_word(OP_LOOKUP, 31'd128, 32'd0);
		send_word(OP_LOOKUP, 31'd0, 32'd0);
		send_word(OP_REMOVE, 31'd0, 32'd0);
		send_word(OP_LOOKUP, 31'h7FFFFFFF, 32'd0);
		send_word(OP_CLEAR, 31'h7FFFFFFF, 32'hFFFFFFFF);
		// fill the pool so the last new key finds it full, then re-add a key already held
		for (int i = 0; i < 257; i++) send_word(OP_ADD, 31'(i * 3), 32'(i));
		send_word(OP_ADD, 31'd3, 32'd9);
		send_word(OP_CLEAR, 31'd0, 32'd0);
		write_buckets(7'd0);
		random_phase(40);
		write_buckets(7'd1);
		random_phase(30);
		send_idle = 81; recv_idle = 15;
		write_buckets(7'd127);
		random_phase(30);
		write_buckets(7'd7);
		send_word(OP_CLEAR, 31'd0, 32'd0);
		random_phase(30);
		send_idle = 0; recv_idle = 0;
		write_buckets(7'd64);
		random_phase(30);
		write_buckets(7'd33);
		random_phase(20);
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("covered %0d requests over bucket counts 0, 1, 127, 7, 64, 33", sent_items);
		$display("including pool full, chain collisions, misses and clears");
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
